// ===== rtl/slg_pkg.sv =====
package slg_pkg;

   // Width of one stored key (the signed value with its sign bit flipped).
   localparam int KEY_W = 32;

   // Sequencer states, one-hot.
   typedef enum logic [2:0] {
      ST_LOAD = 3'b001,
      ST_SCAN = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   // Control shared by every cell of the chain.
   typedef struct packed {
      logic insert;
      logic drain;
   } cell_ctl_type;

   // Control of the gap scan unit.
   typedef struct packed {
      logic clear;
      logic step;
   } scan_ctl_type;

endpackage

// ===== rtl/slg_cell.sv =====
module slg_cell
   import slg_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cell_ctl_type     ctl,
   input  logic [KEY_W-1:0] key,
   input  logic [KEY_W-1:0] lo_value,
   input  logic             lo_valid,
   input  logic             lo_gt,
   input  logic [KEY_W-1:0] hi_value,
   input  logic             hi_valid,
   output logic [KEY_W-1:0] value,
   output logic             valid,
   output logic             gt
);

   logic [KEY_W-1:0] value_ff, value_in;
   logic             valid_ff, valid_in;

   // An empty cell counts as holding a key above every new key.
   assign gt    = !valid_ff || (value_ff > key);
   assign value = value_ff;
   assign valid = valid_ff;

   // Insert: take the lower neighbor's entry if it also moves up, else take the key.
   // Drain: take the upper neighbor's entry so the chain empties toward cell zero.
   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctl.insert && gt) begin
         if (lo_gt) begin
            value_in = lo_value;
            valid_in = lo_valid;
         end else begin
            value_in = key;
            valid_in = 1'b1;
         end
      end else if (ctl.drain) begin
         value_in = hi_value;
         valid_in = hi_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// ===== rtl/slg_gap.sv =====
module slg_gap
   import slg_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  scan_ctl_type     ctl,
   input  logic [KEY_W-1:0] head,
   input  logic             head_valid,
   output logic [KEY_W-1:0] best
);

   logic [KEY_W-1:0] prev_ff;
   logic [KEY_W-1:0] best_ff;
   logic             have_ff;
   logic [KEY_W-1:0] diff;

   // Keys arrive in ascending order, so the difference is never negative.
   assign diff = head - prev_ff;
   assign best = best_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
      end else if (ctl.clear) begin
         have_ff <= 1'b0;
      end else if (ctl.step && head_valid) begin
         have_ff <= 1'b1;
      end
   end

   // Running maximum of neighbor differences.
   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         best_ff <= '0;
      end else if (ctl.step && head_valid) begin
         prev_ff <= head;
         if (have_ff && (diff > best_ff)) begin
            best_ff <= diff;
         end
      end
   end

endmodule

// ===== rtl/sorted_largest_gap.sv =====
// Channel  Direction  Signals                       Word contents
// req      in         req_tvalid/tready/tdata/tlast tdata[31:0] value, tlast closes the set
// rsp      out        rsp_tvalid/tready/tdata/tuser tdata[31:0] gap, tuser overflow
//
// While a set loads, one word is taken every cycle; each value is sorted in place
// by the insertion chain of MAX_ITEMS cells as it arrives; once the chain is full,
// further values are dropped and flagged as overflow. After the closing word, the
// chain drains through the gap unit, and no word is taken until the result is in
// the output register. Reset is synchronous and active high and empties the chain.
// A stalled result holds in the output register, then in the sequencer.
module sorted_largest_gap
   import slg_pkg::*;
#(
   parameter int MAX_ITEMS = 64
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] gap
   output logic        rsp_tuser    // [0] overflow
);

   localparam int CNT_W = $clog2(MAX_ITEMS + 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             dropped_ff, dropped_in;
   logic             ovf_ff, ovf_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [KEY_W-1:0] rsp_gap_ff;
   logic             rsp_ovf_ff;
   logic             load_rsp;

   logic             accept;
   logic             full;
   logic             out_free;
   logic [KEY_W-1:0] key;
   cell_ctl_type     cell_ctl;
   scan_ctl_type     scan_ctl;
   logic [KEY_W-1:0] best;

   logic [KEY_W-1:0] cell_value [MAX_ITEMS];
   logic             cell_valid [MAX_ITEMS];
   logic             cell_gt    [MAX_ITEMS];

   assign req_tready = (state_ff == ST_LOAD);
   assign accept     = req_tvalid && req_tready;
   assign full       = (fill_ff == CNT_W'(MAX_ITEMS));
   assign out_free   = !rsp_valid_ff || rsp_tready;
   // Flip the sign bit so unsigned order matches signed order.
   assign key        = {~req_tdata[KEY_W-1], req_tdata[KEY_W-2:0]};

   assign cell_ctl.insert = accept && !full;
   assign cell_ctl.drain  = (state_ff == ST_SCAN);
   assign scan_ctl.clear  = accept && req_tlast;
   assign scan_ctl.step   = (state_ff == ST_SCAN);

   // Insertion chain, cell zero holds the smallest key.
   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      slg_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (cell_ctl),
         .key      (key),
         .lo_value ((i == 0) ? key  : cell_value[(i == 0) ? 0 : i - 1]),
         .lo_valid ((i == 0) ? 1'b0 : cell_valid[(i == 0) ? 0 : i - 1]),
         .lo_gt    ((i == 0) ? 1'b0 : cell_gt[(i == 0) ? 0 : i - 1]),
         .hi_value ((i == MAX_ITEMS - 1) ? '0 :
                    cell_value[(i == MAX_ITEMS - 1) ? i : i + 1]),
         .hi_valid ((i == MAX_ITEMS - 1) ? 1'b0 :
                    cell_valid[(i == MAX_ITEMS - 1) ? i : i + 1]),
         .value    (cell_value[i]),
         .valid    (cell_valid[i]),
         .gt       (cell_gt[i])
      );
   end

   // Gap scan over the draining head of the chain.
   slg_gap u_gap (
      .clock      (clock),
      .reset      (reset),
      .ctl        (scan_ctl),
      .head       (cell_value[0]),
      .head_valid (cell_valid[0]),
      .best       (best)
   );

   // Sequencer, fill count and drop tracking.
   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      dropped_in = dropped_ff;
      ovf_in     = ovf_ff;
      load_rsp   = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (req_tlast) begin
                  ovf_in     = dropped_ff || full;
                  fill_in    = '0;
                  dropped_in = 1'b0;
                  state_in   = ST_SCAN;
               end else if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  fill_in = fill_ff + CNT_W'(1);
               end
            end
         end
         ST_SCAN: begin
            if (!cell_valid[0]) begin
               if (out_free) begin
                  load_rsp = 1'b1;
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               load_rsp = 1'b1;
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Output register valid.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         fill_ff      <= '0;
         dropped_ff   <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         dropped_ff   <= dropped_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_gap_ff <= best;
         rsp_ovf_ff <= ovf_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_gap_ff;
   assign rsp_tuser  = rsp_ovf_ff;

endmodule
